FILE: hw/rtl/nrle_pkg.sv
// Shared types and constants for the nibble run-length encoder.
// No dependencies; used by the front, queue, back and top-level files.
package nrle_pkg;

   localparam logic [3:0]  LEVEL_BLACK = 4'h0;
   localparam logic [3:0]  LEVEL_WHITE = 4'hF;
   localparam logic [11:0] WIDE_CAP    = 12'hFFF;
   localparam logic [11:0] NARROW_CAP  = 12'h00F;

   // Run queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One closed run
   typedef struct packed {
      logic        valid;
      logic [3:0]  level;
      logic [11:0] length;
   } run_type;

   // Everything one request sends: the run closed by a level change,
   // then the run closed by its cap or by end of image.
   typedef struct packed {
      run_type     run0;
      run_type     run1;
      logic        eoi;
   } entry_type;

   // Black and white take the long two-byte form
   function automatic logic level_is_wide(input logic [3:0] lvl);
      return (lvl == LEVEL_BLACK) || (lvl == LEVEL_WHITE);
   endfunction

endpackage

FILE: hw/rtl/nibble_run_length_encoder_top.sv
// Nibble run-length encoder, top level: front end, run queue, back end.
// Depends on nrle_pkg, nrle_front, nrle_queue and nrle_back.
//
// One raster byte is taken per cycle while the four-entry run queue has room;
// its upper nibble is the gray level. Each request causes zero to four encoded
// bytes, and the back end delivers one byte per cycle from its output
// register while runs are queued and the consumer pops; over a stream the
// byte output rate of one per cycle sets the throughput. With the output
// register free, the first byte of a request passes through the run queue
// and then the output register before it shows on the result ports.
// No clearing pass is needed after reset.
module nibble_run_length_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_pixel_byte,
   input  logic       req_end_of_image,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_item,
   output logic       rsp_last_of_image
);

   nrle_pkg::entry_type q_data;
   nrle_pkg::entry_type q_head;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;

   nrle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_pixel_byte   (req_pixel_byte),
      .req_end_of_image (req_end_of_image),
      .req_full         (req_full),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   nrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   nrle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_last_of_image (rsp_last_of_image)
   );

   // Front never writes a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed into a full run queue");

   // Back never pops an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back popped an empty run queue");

   // Queue fill flags are consistent
   a_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("run queue both full and empty");

   // End of image only on the final byte of a request
   a_image_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_of_image) |-> rsp_last_of_item)
      else $error("last_of_image without last_of_item");

endmodule

FILE: hw/rtl/nrle_front.sv
// Front end: takes one raster byte per request, tracks the open run and
// classifies which runs close. Depends on nrle_pkg.
module nrle_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_pixel_byte,
   input  logic                 req_end_of_image,
   output logic                 req_full,
   input  logic                 q_full,
   output logic                 q_push,
   output nrle_pkg::entry_type  q_data
);

   logic        run_open_ff, run_open_in;
   logic [3:0]  run_level_ff, run_level_in;
   logic [11:0] run_length_ff, run_length_in;

   logic        accept;
   logic [3:0]  lvl;
   logic        change;
   logic        extend;
   logic [11:0] cur_len;
   logic        cap_hit;
   logic        close;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign lvl      = req_pixel_byte[7:4];

   // Classify the request against the open run
   always_comb begin
      change  = run_open_ff && (run_level_ff != lvl);
      extend  = run_open_ff && !change;
      cur_len = extend ? (run_length_ff + 12'd1) : 12'd1;
      if (nrle_pkg::level_is_wide(lvl)) begin
         cap_hit = (cur_len >= nrle_pkg::WIDE_CAP);
      end else begin
         cap_hit = (cur_len >= nrle_pkg::NARROW_CAP);
      end
      close = cap_hit || req_end_of_image;
   end

   // Queue entry: old run on a level change, current run when it closes
   always_comb begin
      q_data.run0.valid  = change;
      q_data.run0.level  = run_level_ff;
      q_data.run0.length = run_length_ff;
      q_data.run1.valid  = close;
      q_data.run1.level  = lvl;
      q_data.run1.length = cur_len;
      q_data.eoi         = req_end_of_image;
      q_push             = accept && (change || close);
   end

   // Next run state
   always_comb begin
      run_open_in   = run_open_ff;
      run_level_in  = run_level_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         run_open_in   = !close;
         run_level_in  = lvl;
         run_length_in = close ? 12'd0 : cur_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         run_level_ff  <= 4'd0;
         run_length_ff <= 12'd0;
      end else begin
         run_open_ff   <= run_open_in;
         run_level_ff  <= run_level_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

FILE: hw/rtl/nrle_queue.sv
// Short run queue between front and back end.
// Depends on nrle_pkg for the entry type and depth.
module nrle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  nrle_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output nrle_pkg::entry_type  head,
   output logic                 empty
);

   nrle_pkg::entry_type mem_ff [nrle_pkg::QUEUE_DEPTH];

   logic [nrle_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nrle_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nrle_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full    = (count_ff == nrle_pkg::QUEUE_CNT_W'(nrle_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/nrle_back.sv
// Back end: turns queued runs into encoded bytes, one per cycle into an output
// register while runs wait and it is free or popped. Depends on nrle_pkg.
module nrle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  nrle_pkg::entry_type  head,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_item,
   output logic                 rsp_last_of_image
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       last_item_ff;
   logic       last_image_ff;

   logic [1:0] n0;
   logic [1:0] n1;
   logic [2:0] total;
   logic       is_last;
   logic       load;
   logic [7:0] sel_byte;

   // Byte s of a run in its encoded form
   function automatic logic [7:0] run_byte(input nrle_pkg::run_type r, input logic s);
      logic [7:0] b;
      if (nrle_pkg::level_is_wide(r.level)) begin
         b = s ? r.length[7:0] : {r.level, r.length[11:8]};
      end else begin
         b = {r.level, r.length[3:0]};
      end
      return b;
   endfunction

   // Byte counts and selection within the head entry
   always_comb begin
      n0 = !head.run0.valid ? 2'd0 :
           (nrle_pkg::level_is_wide(head.run0.level) ? 2'd2 : 2'd1);
      n1 = !head.run1.valid ? 2'd0 :
           (nrle_pkg::level_is_wide(head.run1.level) ? 2'd2 : 2'd1);
      total   = {1'b0, n0} + {1'b0, n1};
      is_last = (({1'b0, idx_ff} + 3'd1) == total);
      if (idx_ff < n0) begin
         sel_byte = run_byte(head.run0, idx_ff[0]);
      end else begin
         sel_byte = run_byte(head.run1, 1'(idx_ff - n0));
      end
   end

   assign load      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = load && is_last;
   assign rsp_empty = !out_valid_ff;

   // Control next state
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= sel_byte;
         last_item_ff  <= is_last;
         last_image_ff <= is_last && head.eoi;
      end
   end

   assign rsp_out_byte      = byte_ff;
   assign rsp_last_of_item  = last_item_ff;
   assign rsp_last_of_image = last_image_ff;

endmodule
